// ----- sv/psh_pkg.sv -----
// ---------------------------------------------------------------------------
// psh_pkg
// Shared types and constants of the priority heap task scheduler.
// ---------------------------------------------------------------------------
package psh_pkg;

  localparam int MAX_READY = 16;
  localparam int IDX_W     = $clog2(MAX_READY);
  localparam int CNT_W     = $clog2(MAX_READY + 1);
  // child index width, wide enough for 2*pos+2 without wrapping
  localparam int PW        = IDX_W + 2;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } ent_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_START,
    OP_INS_READ,
    OP_INS_CMP,
    OP_PLACE,
    OP_POP_START,
    OP_READ_LAST,
    OP_TAKE_LAST,
    OP_POP_READ,
    OP_POP_CMP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic count_zero;
    logic pos_zero;
    logic ins_stop;
    logic pop_leaf;
    logic pop_stop;
    logic sched_keep;
    logic sched_push;
  } dp_sts_t;

endpackage

// ----- sv/psh_ctrl.sv -----
// ---------------------------------------------------------------------------
// psh_ctrl
// Sequencer for the heap scheduler: walks insert and pop sift loops and
// hands each finished transaction to the output register.
// ---------------------------------------------------------------------------
module psh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  input  psh_pkg::dp_sts_t sts,
  output psh_pkg::ctl_cmd_t cmd
);
  import psh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_START,
    S_INS_RD,
    S_INS_CMP,
    S_POP_START,
    S_POP_RDLAST,
    S_POP_TAKE,
    S_POP_RD,
    S_POP_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  state_t ins_exit;

  // a schedule transaction continues with a pop after its push-back
  assign ins_exit = sts.kind ? S_POP_START : S_FIN;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.kind) begin
          state_nxt = S_INS_START;
        end else if (sts.sched_keep) begin
          state_nxt = S_FIN;
        end else if (sts.sched_push) begin
          state_nxt = S_INS_START;
        end else if (sts.count_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_POP_START;
        end
      end
      S_INS_START: begin
        cmd.op    = OP_INS_START;
        state_nxt = sts.full ? ins_exit : S_INS_RD;
      end
      S_INS_RD: begin
        if (sts.pos_zero) begin
          cmd.op    = OP_PLACE;
          state_nxt = ins_exit;
        end else begin
          cmd.op    = OP_INS_READ;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.op    = OP_INS_CMP;
        state_nxt = sts.ins_stop ? ins_exit : S_INS_RD;
      end
      S_POP_START: begin
        cmd.op    = OP_POP_START;
        state_nxt = S_POP_RDLAST;
      end
      S_POP_RDLAST: begin
        if (sts.count_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_READ_LAST;
          state_nxt = S_POP_TAKE;
        end
      end
      S_POP_TAKE: begin
        cmd.op    = OP_TAKE_LAST;
        state_nxt = S_POP_RD;
      end
      S_POP_RD: begin
        if (sts.pop_leaf) begin
          cmd.op    = OP_PLACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_POP_READ;
          state_nxt = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        cmd.op    = OP_POP_CMP;
        state_nxt = sts.pop_stop ? S_FIN : S_POP_RD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/psh_dp.sv -----
// ---------------------------------------------------------------------------
// psh_dp
// Heap datapath: heap memory with two registered read ports, root shadow,
// current-task register, sift position and comparators.
// ---------------------------------------------------------------------------
module psh_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  psh_pkg::ctl_cmd_t         cmd,
  output psh_pkg::dp_sts_t          sts,
  input  logic                      in_kind,
  input  logic [7:0]                in_task_id,
  input  logic [7:0]                in_task_priority,
  input  logic                      in_current_runnable,
  output logic [7:0]                res_running_id,
  output logic [7:0]                res_running_priority,
  output logic                      res_running_valid,
  output logic                      res_switched,
  output logic                      res_dropped,
  output logic [psh_pkg::CNT_W-1:0] res_ready_count
);
  import psh_pkg::*;

  ent_t heap_mem [MAX_READY];

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] pos_r;
  ent_t             key_r, top_r, cur_r, item_r;
  ent_t             rd_a_r, rd_b_r;
  logic             cur_valid_r, switched_r, dropped_r, kind_r, run_r;

  logic [IDX_W-1:0] parent, rd_addr_a, rd_addr_b, wr_addr, big_idx;
  logic [PW-1:0]    lchild, rchild, cnt_ext;
  logic             big_is_r, wr_en;
  ent_t             big, wr_data;

  assign parent   = (pos_r - IDX_W'(1)) >> 1;
  assign lchild   = {1'b0, pos_r, 1'b1};
  assign rchild   = lchild + PW'(1);
  assign cnt_ext  = {{(PW-CNT_W){1'b0}}, count_r};
  assign big_is_r = (rchild < cnt_ext) && (rd_b_r.prio > rd_a_r.prio);
  assign big      = big_is_r ? rd_b_r : rd_a_r;
  assign big_idx  = big_is_r ? rchild[IDX_W-1:0] : lchild[IDX_W-1:0];

  assign sts.kind       = kind_r;
  assign sts.full       = (count_r == CNT_W'(MAX_READY));
  assign sts.count_zero = (count_r == '0);
  assign sts.pos_zero   = (pos_r == '0);
  assign sts.ins_stop   = (rd_a_r.prio >= key_r.prio);
  assign sts.pop_leaf   = (lchild >= cnt_ext);
  assign sts.pop_stop   = (key_r.prio >= big.prio);
  assign sts.sched_keep = cur_valid_r && run_r &&
                          ((count_r == '0) || (cur_r.prio >= top_r.prio));
  assign sts.sched_push = cur_valid_r && run_r && !sts.sched_keep;

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (cmd.op)
      OP_INS_READ:  rd_addr_a = parent;
      OP_READ_LAST: rd_addr_a = count_r[IDX_W-1:0];
      OP_POP_READ: begin
        rd_addr_a = lchild[IDX_W-1:0];
        rd_addr_b = rchild[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = key_r;
    case (cmd.op)
      OP_PLACE: wr_en = 1'b1;
      OP_INS_CMP: begin
        wr_en   = 1'b1;
        wr_data = sts.ins_stop ? key_r : rd_a_r;
      end
      OP_POP_CMP: begin
        wr_en   = 1'b1;
        wr_data = sts.pop_stop ? key_r : big;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= heap_mem[rd_addr_a];
    rd_b_r <= heap_mem[rd_addr_b];
  end

  // shadow copy of the root, so schedule decisions need no memory read
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      top_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      switched_r  <= 1'b0;
      dropped_r   <= 1'b0;
      kind_r      <= 1'b0;
      run_r       <= 1'b0;
      pos_r       <= '0;
      key_r       <= '0;
      item_r      <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          kind_r     <= in_kind;
          item_r     <= '{id: in_task_id, prio: in_task_priority};
          run_r      <= in_current_runnable;
          switched_r <= 1'b0;
          dropped_r  <= 1'b0;
        end
        OP_INS_START: begin
          if (sts.full) begin
            dropped_r <= 1'b1;
          end else begin
            pos_r   <= count_r[IDX_W-1:0];
            count_r <= count_r + CNT_W'(1);
            key_r   <= kind_r ? cur_r : item_r;
          end
        end
        OP_INS_CMP: begin
          if (!sts.ins_stop) begin
            pos_r <= parent;
          end
        end
        OP_POP_START: begin
          cur_r       <= top_r;
          cur_valid_r <= 1'b1;
          switched_r  <= 1'b1;
          count_r     <= count_r - CNT_W'(1);
        end
        OP_TAKE_LAST: begin
          key_r <= rd_a_r;
          pos_r <= '0;
        end
        OP_POP_CMP: begin
          if (!sts.pop_stop) begin
            pos_r <= big_idx;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_running_id       = cur_r.id;
  assign res_running_priority = cur_r.prio;
  assign res_running_valid    = cur_valid_r;
  assign res_switched         = switched_r;
  assign res_dropped          = dropped_r;
  assign res_ready_count      = count_r;

endmodule

// ----- sv/priority_heap_task_scheduler.sv -----
// ---------------------------------------------------------------------------
// priority_heap_task_scheduler
// Ready-queue scheduler on a binary max-heap with a current-task register.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// for each. The heap lives in a memory with registered reads, so every heap
// level visited takes a read step, then a compare and write step. A ready
// transaction is loaded, placed at the new last slot and sifted up until its
// parent is at least as high or it reaches the root; it is dropped when the
// heap is full. A schedule transaction that keeps its task, or finds the heap
// empty, goes straight to its result; one that pops takes the root, moves the
// last entry there and sifts it down, and a push-back of the current task is
// inserted before the pop. Once the output register is free the result is
// loaded into it, and a new transaction is accepted as soon as the previous
// result sits in the output register, even if it is not yet taken. No
// clearing pass is needed after reset.
module priority_heap_task_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [7:0]                in_task_id,
  input  logic [7:0]                in_task_priority,
  input  logic                      in_current_runnable,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_running_id,
  output logic [7:0]                out_running_priority,
  output logic                      out_running_valid,
  output logic                      out_switched,
  output logic                      out_dropped,
  output logic [psh_pkg::CNT_W-1:0] out_ready_count
);
  import psh_pkg::*;

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic             out_valid_r, out_free;
  logic [7:0]       res_id, res_prio;
  logic             res_valid, res_switched, res_dropped;
  logic [CNT_W-1:0] res_count;

  assign out_free = !out_valid_r || out_ready;

  psh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  psh_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_kind              (in_kind),
    .in_task_id           (in_task_id),
    .in_task_priority     (in_task_priority),
    .in_current_runnable  (in_current_runnable),
    .res_running_id       (res_id),
    .res_running_priority (res_prio),
    .res_running_valid    (res_valid),
    .res_switched         (res_switched),
    .res_dropped          (res_dropped),
    .res_ready_count      (res_count)
  );

  // output register decouples the result side from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_running_id       <= res_id;
      out_running_priority <= res_prio;
      out_running_valid    <= res_valid;
      out_switched         <= res_switched;
      out_dropped          <= res_dropped;
      out_ready_count      <= res_count;
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_count <= CNT_W'(MAX_READY)))
    else $error("ready count above heap depth");

  a_switch_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> out_running_valid)
    else $error("switch reported without a current task");

  a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |->
      ((out_ready_count == CNT_W'(MAX_READY)) ||
       (out_switched && (out_ready_count == CNT_W'(MAX_READY - 1)))))
    else $error("drop reported while heap had room");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the priority heap task scheduler.
// ---------------------------------------------------------------------------
// A short table of directed transactions covers the empty, single-entry and
// full heap. Random phases follow that fill, drain or mix the ready heap. A
// behavioural copy of the heap and the current-task register predicts each
// result. Both handshake sides idle at random, and the result side stalls
// once for a long stretch so that the input backs up.
module tb;

  localparam logic KIND_READY = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  localparam int PRIO_NARROW  = 0;
  localparam int PRIO_FULL    = 1;
  localparam int PRIO_EXTREME = 2;

  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0]                id;
    logic [7:0]                prio;
    logic                      valid;
    logic                      sw;
    logic                      dr;
    logic [psh_pkg::CNT_W-1:0] cnt;
  } sched_res_t;

  typedef struct {
    logic       kind;
    logic [7:0] id;
    logic [7:0] prio;
    logic       runnable;
    bit         typed;
    sched_res_t exp;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_kind;
  logic [7:0]                in_task_id;
  logic [7:0]                in_task_priority;
  logic                      in_current_runnable;
  logic                      out_valid;
  logic                      out_ready;
  logic [7:0]                out_running_id;
  logic [7:0]                out_running_priority;
  logic                      out_running_valid;
  logic                      out_switched;
  logic                      out_dropped;
  logic [psh_pkg::CNT_W-1:0] out_ready_count;

  // predicted scheduler state
  logic [7:0] rq_id   [psh_pkg::MAX_READY];
  logic [7:0] rq_prio [psh_pkg::MAX_READY];
  int         rq_count;
  logic [7:0] run_id;
  logic [7:0] run_prio;
  logic       run_valid;

  sched_res_t pending_status[$];
  stim_row_t  stim_rows[$];
  int         fault_count;
  int         rx_count;

  priority_heap_task_scheduler DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_task_id           (in_task_id),
    .in_task_priority     (in_task_priority),
    .in_current_runnable  (in_current_runnable),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_running_id       (out_running_id),
    .out_running_priority (out_running_priority),
    .out_running_valid    (out_running_valid),
    .out_switched         (out_switched),
    .out_dropped          (out_dropped),
    .out_ready_count      (out_ready_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit ready_push(input logic [7:0] id, input logic [7:0] pr);
    int pos;
    int up;
    if (rq_count >= psh_pkg::MAX_READY) return 1'b0;
    pos = rq_count;
    rq_count++;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (rq_prio[up] >= pr) break;
      rq_id[pos]   = rq_id[up];
      rq_prio[pos] = rq_prio[up];
      pos = up;
    end
    rq_id[pos]   = id;
    rq_prio[pos] = pr;
    return 1'b1;
  endfunction

  // takes the root; the moved last entry stops on equal, left child wins a tie
  function automatic void ready_pop(output logic [7:0] id, output logic [7:0] pr);
    logic [7:0] mid;
    logic [7:0] mpr;
    int pos;
    int l;
    int big;
    id = rq_id[0];
    pr = rq_prio[0];
    rq_count--;
    if (rq_count > 0) begin
      mid = rq_id[rq_count];
      mpr = rq_prio[rq_count];
      pos = 0;
      while (2 * pos + 1 < rq_count) begin
        l = 2 * pos + 1;
        big = l;
        if (l + 1 < rq_count && rq_prio[l + 1] > rq_prio[l]) big = l + 1;
        if (mpr >= rq_prio[big]) break;
        rq_id[pos]   = rq_id[big];
        rq_prio[pos] = rq_prio[big];
        pos = big;
      end
      rq_id[pos]   = mid;
      rq_prio[pos] = mpr;
    end
  endfunction

  function automatic sched_res_t sched_outcome(input logic kind, input logic [7:0] id,
                                               input logic [7:0] pr, input logic runnable);
    sched_res_t r;
    bit need;
    r.sw = 1'b0;
    r.dr = 1'b0;
    if (kind == KIND_READY) begin
      if (!ready_push(id, pr)) r.dr = 1'b1;
    end else begin
      need = 1'b1;
      if (run_valid && runnable) begin
        if (rq_count == 0 || run_prio >= rq_prio[0]) need = 1'b0;
        if (need && !ready_push(run_id, run_prio)) r.dr = 1'b1;
      end
      if (need && rq_count > 0) begin
        ready_pop(run_id, run_prio);
        run_valid = 1'b1;
        r.sw = 1'b1;
      end
    end
    r.id    = run_id;
    r.prio  = run_prio;
    r.valid = run_valid;
    r.cnt   = rq_count[psh_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic sched_res_t mk_res(input logic [7:0] id, input logic [7:0] pr,
                                        input logic v, input logic sw, input logic dr,
                                        input int cnt);
    sched_res_t r;
    r.id    = id;
    r.prio  = pr;
    r.valid = v;
    r.sw    = sw;
    r.dr    = dr;
    r.cnt   = cnt[psh_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic kind, input logic [7:0] id,
                                  input logic [7:0] pr, input logic runnable,
                                  input bit typed, input sched_res_t exp);
    stim_row_t row;
    row.kind     = kind;
    row.id       = id;
    row.prio     = pr;
    row.runnable = runnable;
    row.typed    = typed;
    row.exp      = exp;
    stim_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input stim_row_t row, input bit allow_gap);
    sched_res_t e;
    if (allow_gap) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid            <= 1'b1;
    in_kind             <= row.kind;
    in_task_id          <= row.id;
    in_task_priority    <= row.prio;
    in_current_runnable <= row.runnable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = sched_outcome(row.kind, row.id, row.prio, row.runnable);
    if (row.typed) e = row.exp;
    pending_status.push_back(e);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t e;
    if (rst_n && out_valid && out_ready) begin
      rx_count <= rx_count + 1;
      got.id    = out_running_id;
      got.prio  = out_running_priority;
      got.valid = out_running_valid;
      got.sw    = out_switched;
      got.dr    = out_dropped;
      got.cnt   = out_ready_count;
      if (pending_status.size() == 0) begin
        if (fault_count < 10) $display("unexpected result transaction: %p", got);
        fault_count++;
      end else begin
        e = pending_status.pop_front();
        if (got.id !== e.id || got.prio !== e.prio || got.valid !== e.valid ||
            got.sw !== e.sw || got.dr !== e.dr || got.cnt !== e.cnt) begin
          if (fault_count < 10)
            $display("mismatch at result %0d: expected %p, got %p", rx_count, e, got);
          fault_count++;
        end
      end
    end
  end

  // result side: random stalls, one long hold-off, and a stretch with none
  initial begin
    int k;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && rx_count >= 250) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        out_ready <= 1'b1;
      end else if (rx_count >= 600 && rx_count < 800) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t  row;
    sched_res_t none;
    int i;
    int j;
    int sent;
    int phase_len;
    int mode;
    int prio_mode;
    int ready_pct;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = KIND_READY;
    in_task_id          = 8'h00;
    in_task_priority    = 8'h00;
    in_current_runnable = 1'b0;
    fault_count         = 0;
    rx_count            = 0;
    rq_count            = 0;
    run_id              = 8'h00;
    run_prio            = 8'h00;
    run_valid           = 1'b0;
    none                = '0;

    // empty heap with no current task, then single entries at the extremes
    add_row(KIND_SCHED, 8'hA5, 8'h5A, 1'b1, 1'b1,
            mk_res(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 0));
    add_row(KIND_SCHED, 8'h5A, 8'hA5, 1'b0, 1'b1,
            mk_res(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 0));
    add_row(KIND_READY, 8'hFF, 8'h00, 1'b0, 1'b1,
            mk_res(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1));
    add_row(KIND_SCHED, 8'h00, 8'hFF, 1'b1, 1'b1,
            mk_res(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 0));
    add_row(KIND_READY, 8'h00, 8'hFF, 1'b1, 1'b1,
            mk_res(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 1));
    // lower current task yields and goes back into the heap
    add_row(KIND_SCHED, 8'h00, 8'h00, 1'b1, 1'b1,
            mk_res(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1));
    add_row(KIND_SCHED, 8'hFF, 8'hFF, 1'b1, 1'b1,
            mk_res(8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 1));
    // blocked current task is not pushed back
    add_row(KIND_SCHED, 8'h00, 8'h00, 1'b0, 1'b1,
            mk_res(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 0));
    // fill to capacity with tied priorities
    for (i = 0; i < psh_pkg::MAX_READY; i++)
      add_row(KIND_READY, 8'(8'h10 + i), 8'((i % 5) * 50), 1'b0, 1'b0, none);
    add_row(KIND_READY, 8'h7E, 8'hFF, 1'b1, 1'b1,
            mk_res(8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, psh_pkg::MAX_READY));
    // yielding task lost because the heap is full
    add_row(KIND_SCHED, 8'h00, 8'h00, 1'b1, 1'b0, none);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[n]) offer(stim_rows[n], 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 60);
      mode      = $urandom_range(MODE_FILL, MODE_MIXED);
      prio_mode = $urandom_range(PRIO_NARROW, PRIO_EXTREME);
      case (mode)
        MODE_FILL:  ready_pct = 80;
        MODE_DRAIN: ready_pct = 25;
        default:    ready_pct = 50;
      endcase
      for (j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        row.kind = ($urandom_range(0, 99) < ready_pct) ? KIND_READY : KIND_SCHED;
        row.id   = 8'($urandom_range(0, 255));
        case (prio_mode)
          PRIO_NARROW: row.prio = 8'($urandom_range(0, 3));
          PRIO_FULL:   row.prio = 8'($urandom_range(0, 255));
          default:     row.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        row.runnable = ($urandom_range(0, 99) < 70);
        row.typed    = 1'b0;
        row.exp      = none;
        // no sender gaps over a long stretch
        offer(row, !(sent >= 400 && sent < 650));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
